FILE: hdl/ffea_pkg.sv
`timescale 1ns / 1ps

package ffea_pkg;

   // table geometry
   localparam int MAX_EXTENTS = 16;
   localparam int OFFSET_BITS = 24;
   localparam int LEN_BITS    = OFFSET_BITS + 1;
   localparam int SUM_BITS    = LEN_BITS + 1;
   localparam int IDX_BITS    = $clog2(MAX_EXTENTS);
   localparam int CNT_BITS    = IDX_BITS + 1;

   localparam logic [LEN_BITS-1:0] BUF_LIMIT = LEN_BITS'(1) << OFFSET_BITS;
   localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(MAX_EXTENTS);

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // write data selects
   localparam logic [2:0] WR_COPY   = 3'd0;
   localparam logic [2:0] WR_CARVE  = 3'd1;
   localparam logic [2:0] WR_MERGE1 = 3'd2;
   localparam logic [2:0] WR_MERGE2 = 3'd3;
   localparam logic [2:0] WR_NEXT   = 3'd4;
   localparam logic [2:0] WR_NEW    = 3'd5;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    len;
   } entry_type;

   typedef struct packed {
      logic                load_req;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [2:0]          wr_sel;
      logic                keep_prev;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                tot_add;
      logic                tot_sub;
      logic                set_grant;
      logic                set_full;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic                op_free;
      logic                size_zero;
      logic [CNT_BITS-1:0] count;
      logic                fit;
      logic                exact;
      logic                gt_ofs;
      logic                prev_hit;
      logic                next_hit_prev;
      logic                next_hit_new;
      logic                rsp_free;
   } sts_type;

   // saturating length add
   function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
   endfunction

endpackage

FILE: hdl/ffea_ctrl.sv
`timescale 1ns / 1ps

module ffea_ctrl
   import ffea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_EV     = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_DN     = 4'd5;
   localparam logic [3:0] S_DN_WR  = 4'd6;
   localparam logic [3:0] S_UP     = 4'd7;
   localparam logic [3:0] S_UP_WR  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] ptr_ff, ptr_in;
   logic [CNT_BITS-1:0] idx_nx, idx_pv, ptr_nx, ptr_pv;
   logic                have_cur;

   assign req_tready = (state_ff == S_IDLE);
   assign idx_nx     = idx_ff + CNT_BITS'(1);
   assign idx_pv     = idx_ff - CNT_BITS'(1);
   assign ptr_nx     = ptr_ff + CNT_BITS'(1);
   assign ptr_pv     = ptr_ff - CNT_BITS'(1);
   assign have_cur   = (idx_ff < sts.count);

   // sequence scan, merge and shift steps
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      cmd      = '0;
      cmd.rd_addr = idx_ff[IDX_BITS-1:0];
      cmd.wr_addr = idx_ff[IDX_BITS-1:0];
      cmd.wr_sel  = WR_COPY;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               state_in     = S_START;
            end
         end
         S_START: begin
            if (sts.op_free && sts.size_zero) begin
               state_in = S_DONE;
            end else if (sts.count == '0) begin
               state_in = sts.op_free ? S_DECIDE : S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EV;
         end
         S_EV: begin
            if (!sts.op_free) begin
               if (sts.fit) begin
                  cmd.set_grant = 1'b1;
                  cmd.tot_sub   = 1'b1;
                  if (sts.exact) begin
                     ptr_in   = idx_ff;
                     state_in = S_DN;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_CARVE;
                     state_in   = S_DONE;
                  end
               end else begin
                  idx_in   = idx_nx;
                  state_in = (idx_nx == sts.count) ? S_DONE : S_RD;
               end
            end else if (sts.gt_ofs) begin
               state_in = S_DECIDE;
            end else begin
               cmd.keep_prev = 1'b1;
               idx_in        = idx_nx;
               state_in      = (idx_nx == sts.count) ? S_DECIDE : S_RD;
            end
         end
         S_DECIDE: begin
            if (sts.prev_hit) begin
               cmd.tot_add = 1'b1;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = idx_pv[IDX_BITS-1:0];
               if (have_cur && sts.next_hit_prev) begin
                  cmd.wr_sel = WR_MERGE2;
                  ptr_in     = idx_ff;
                  state_in   = S_DN;
               end else begin
                  cmd.wr_sel = WR_MERGE1;
                  state_in   = S_DONE;
               end
            end else if (have_cur && sts.next_hit_new) begin
               cmd.tot_add = 1'b1;
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_NEXT;
               state_in    = S_DONE;
            end else if (sts.count < CNT_MAX) begin
               cmd.tot_add = 1'b1;
               ptr_in      = sts.count;
               state_in    = S_UP;
            end else begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end
         end
         // close the gap left by a removed entry
         S_DN: begin
            if (ptr_nx < sts.count) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = ptr_nx[IDX_BITS-1:0];
               state_in    = S_DN_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = ptr_ff[IDX_BITS-1:0];
            ptr_in      = ptr_nx;
            state_in    = S_DN;
         end
         // open a slot for a new entry
         S_UP: begin
            if (ptr_ff > idx_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = ptr_pv[IDX_BITS-1:0];
               state_in    = S_UP_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_UP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = ptr_ff[IDX_BITS-1:0];
            ptr_in      = ptr_pv;
            state_in    = S_UP;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ptr_ff   <= ptr_in;
      end
   end

   // a write and a table read never share a cycle
   assert property (@(posedge clock) disable iff (reset) !(cmd.rd_en && cmd.wr_en))
      else $error("table read and write in the same cycle");
   // a new item is taken only in idle
   assert property (@(posedge clock) disable iff (reset)
                    cmd.load_req |=> $past(state_ff) == S_IDLE)
      else $error("item taken outside idle");
   assert property (@(posedge clock) disable iff (reset)
                    cmd.rsp_load |=> state_ff == S_IDLE)
      else $error("result load did not return to idle");

endmodule

FILE: hdl/ffea_datapath.sv
`timescale 1ns / 1ps

module ffea_datapath
   import ffea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic                   csr_we,
   input  logic [LEN_BITS-1:0]    csr_wdata,
   input  logic                   in_operation,
   input  logic [OFFSET_BITS-1:0] in_region_offset,
   input  logic [LEN_BITS-1:0]    in_region_bytes,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [1:0]             rsp_status,
   output logic [OFFSET_BITS-1:0] rsp_granted_offset,
   output logic [LEN_BITS-1:0]    rsp_free_bytes
);

   entry_type              table_mem [MAX_EXTENTS];
   entry_type              rd_ff;
   logic                   ent0_dflt_ff;
   logic [LEN_BITS-1:0]    buf_ff;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [LEN_BITS-1:0]    total_ff, total_in;
   logic                   op_ff;
   logic [OFFSET_BITS-1:0] ofs_ff;
   logic [LEN_BITS-1:0]    size_ff;
   entry_type              prev_ff;
   logic                   have_prev_ff;
   logic [1:0]             status_ff;
   logic [OFFSET_BITS-1:0] grant_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [OFFSET_BITS-1:0] rsp_grant_ff;
   logic [LEN_BITS-1:0]    rsp_free_ff;

   logic [LEN_BITS-1:0]    csr_sat;
   logic [SUM_BITS-1:0]    prev_end, merge_end, new_end;
   logic [LEN_BITS-1:0]    m1, m2;
   entry_type              wr_data;
   logic [OFFSET_BITS-1:0] carve_start;

   assign csr_sat = (csr_wdata > BUF_LIMIT) ? BUF_LIMIT : csr_wdata;

   // neighbor arithmetic
   assign prev_end    = SUM_BITS'(prev_ff.start) + SUM_BITS'(prev_ff.len);
   assign m1          = sat_add(prev_ff.len, size_ff);
   assign m2          = sat_add(m1, rd_ff.len);
   assign merge_end   = SUM_BITS'(prev_ff.start) + SUM_BITS'(m1);
   assign new_end     = SUM_BITS'(ofs_ff) + SUM_BITS'(size_ff);
   assign carve_start = rd_ff.start + size_ff[OFFSET_BITS-1:0];

   assign sts.op_free       = (op_ff == OP_FREE);
   assign sts.size_zero     = (size_ff == '0);
   assign sts.count         = count_ff;
   assign sts.fit           = (rd_ff.len >= size_ff);
   assign sts.exact         = (rd_ff.len == size_ff);
   assign sts.gt_ofs        = (rd_ff.start > ofs_ff);
   assign sts.prev_hit      = have_prev_ff && (prev_end == SUM_BITS'(ofs_ff));
   assign sts.next_hit_prev = (merge_end == SUM_BITS'(rd_ff.start));
   assign sts.next_hit_new  = (new_end == SUM_BITS'(rd_ff.start));
   assign sts.rsp_free      = !rsp_valid_ff || rsp_tready;

   // select write data
   always_comb begin
      case (cmd.wr_sel)
         WR_COPY:   wr_data = rd_ff;
         WR_CARVE:  wr_data = '{start: carve_start, len: rd_ff.len - size_ff};
         WR_MERGE1: wr_data = '{start: prev_ff.start, len: m1};
         WR_MERGE2: wr_data = '{start: prev_ff.start, len: m2};
         WR_NEXT:   wr_data = '{start: ofs_ff, len: sat_add(rd_ff.len, size_ff)};
         WR_NEW:    wr_data = '{start: ofs_ff, len: size_ff};
         default:   wr_data = rd_ff;
      endcase
   end

   // extent table; entry zero reads as the whole buffer until first written
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         if (cmd.rd_addr == '0 && ent0_dflt_ff) begin
            rd_ff <= '{start: '0, len: buf_ff};
         end else begin
            rd_ff <= table_mem[cmd.rd_addr];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) count_in = count_ff + CNT_BITS'(1);
      if (cmd.cnt_dec) count_in = count_ff - CNT_BITS'(1);
      total_in = total_ff;
      if (cmd.tot_add) total_in = sat_add(total_ff, size_ff);
      if (cmd.tot_sub) total_in = (total_ff >= size_ff) ? total_ff - size_ff : '0;
   end

   // control and bookkeeping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= BUF_LIMIT;
         ent0_dflt_ff <= 1'b1;
         count_ff     <= CNT_BITS'(1);
         total_ff     <= BUF_LIMIT;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_we) begin
         buf_ff       <= csr_sat;
         ent0_dflt_ff <= 1'b1;
         count_ff     <= (csr_sat != '0) ? CNT_BITS'(1) : '0;
         total_ff     <= csr_sat;
      end else begin
         if (cmd.wr_en && cmd.wr_addr == '0) ent0_dflt_ff <= 1'b0;
         count_ff <= count_in;
         total_ff <= total_in;
         if (cmd.load_req) have_prev_ff <= 1'b0;
         else if (cmd.keep_prev) have_prev_ff <= 1'b1;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= in_operation;
         ofs_ff    <= in_region_offset;
         size_ff   <= in_region_bytes;
         status_ff <= (in_operation == OP_ALLOC) ? ST_NOSPACE : ST_OK;
         grant_ff  <= '0;
      end else begin
         if (cmd.set_grant) begin
            status_ff <= ST_OK;
            grant_ff  <= rd_ff.start;
         end
         if (cmd.set_full) status_ff <= ST_FULL;
      end
      if (cmd.keep_prev) prev_ff <= rd_ff;
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_grant_ff  <= grant_ff;
         rsp_free_ff   <= total_ff;
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_grant_ff;
   assign rsp_free_bytes     = rsp_free_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_MAX)
      else $error("extent count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
                    (cmd.wr_en && cmd.wr_sel == WR_NEW) |-> count_ff < CNT_MAX)
      else $error("insert into a full table");
   assert property (@(posedge clock) disable iff (reset)
                    cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule

FILE: hdl/first_fit_extent_allocator_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit up)                         tuser
// req      in         region_offset[23:0], region_bytes[48:24]   operation
// rsp      out        granted_offset[23:0], free_bytes[48:24]    status[1:0]
// csr      in         csr_we / csr_wdata = buffer_bytes (25 bits)
//
// One item at a time. Each scanned extent is read, then evaluated.
// Allocate scans in order; a used-up extent is removed and later entries move down.
// Free scans to the insert point; an insert moves later entries up, a double merge down.
// Zero-size free or allocate on an empty table ends without a scan.
// Reset restores one extent spanning 2^24 bytes; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken;
// the next result holds until that register is free.

module first_fit_extent_allocator_unit
   import ffea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // region_offset, region_bytes, zero pad
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // granted_offset, free_bytes, zero pad
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [24:0] csr_wdata
);

   cmd_type                cmd;
   sts_type                sts;
   logic [OFFSET_BITS-1:0] granted;
   logic [LEN_BITS-1:0]    free_bytes;

   ffea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffea_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .in_operation       (req_tuser),
      .in_region_offset   (req_tdata[23:0]),
      .in_region_bytes    (req_tdata[48:24]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_status         (rsp_tuser),
      .rsp_granted_offset (granted),
      .rsp_free_bytes     (free_bytes)
   );

   assign rsp_tdata = {7'd0, free_bytes, granted};

endmodule
